// ----- design/integer_divmod_unit_assert.svh -----
// -----------------------------------------------------------------------------
// Assertion macros for the integer divide unit
// Concurrent checks on clk, disabled while rst_n is low.
// -----------------------------------------------------------------------------
`ifndef INTEGER_DIVMOD_UNIT_ASSERT_SVH
`define INTEGER_DIVMOD_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define IDU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");
// Next-cycle implication.
`define IDU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define IDU_ASSERT_IMP(lbl, ante, cons)
`define IDU_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- design/idu_pkg.sv -----
// -----------------------------------------------------------------------------
// idu_pkg
// Types and constants shared by the integer divide unit.
// -----------------------------------------------------------------------------
`default_nettype none

package idu_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned HalfW = 32;
  // One quotient bit per pipeline stage.
  localparam int unsigned Steps = DataW;

  localparam logic [DataW-1:0] SIGN_BIT_64 = {1'b1, {(DataW-1){1'b0}}};
  localparam logic [DataW-1:0] SIGN_BIT_32 = {{HalfW{1'b0}}, 1'b1, {(HalfW-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_S32_DIV    = 2'd0,
    KIND_U32_DIV    = 2'd1,
    KIND_U32_DIVMOD = 2'd2,
    KIND_U64_DIVMOD = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t        req_type;
    logic [DataW-1:0] numerator;
    logic [DataW-1:0] denominator;
  } div_req_t;

  typedef struct packed {
    logic [DataW-1:0] quotient;
    logic [DataW-1:0] remainder;
    logic             div_by_zero;
  } div_rsp_t;

  // Per-stage working set of the restoring divider.
  typedef struct packed {
    req_kind_t        kind;
    logic [DataW-1:0] nq;    // dividend bits still to enter, quotient bits shift in below
    logic [DataW-1:0] rem;   // partial remainder
    logic [DataW-1:0] dvs;   // divisor magnitude
    logic             qneg;
    logic             rneg;
    logic             dz;
    logic             nz;
  } div_stage_t;

endpackage : idu_pkg

`default_nettype wire

// ----- design/integer_divmod_unit.sv -----
// -----------------------------------------------------------------------------
// integer_divmod_unit
// Pipelined radix-2 restoring divider: signed and unsigned 32 bit, unsigned 64 bit.
// -----------------------------------------------------------------------------
// Pipeline: operand prep, 64 divide stages of one subtract each, result fix-up
//   into the output register.
// Throughput: one transfer per cycle; the pipeline advances as a whole unless
//   the output register is full and stalled, and a one-entry input skid takes
//   the item offered in that cycle.
// Reset: rst_n clears all valid bits and the skid; payload registers keep data.
`default_nettype none

`include "integer_divmod_unit_assert.svh"

module integer_divmod_unit
  import idu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire div_req_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output div_rsp_t      out_data
);

  // ---------------------------------------------------------------------------
  // Input skid and pipeline advance
  // ---------------------------------------------------------------------------
  logic       adv;
  logic       skid_vld_r, skid_vld_nxt;
  div_req_t   skid_r;
  div_req_t   src;
  logic       src_vld;

  logic       out_valid_r;
  div_rsp_t   out_data_r, out_data_nxt;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = skid_vld_r;
  assign src      = skid_vld_r ? skid_r : in_data;
  assign src_vld  = skid_vld_r || in_valid;

  always_comb begin
    skid_vld_nxt = skid_vld_r;
    if (adv) begin
      skid_vld_nxt = 1'b0;
    end else if (in_valid && !skid_vld_r) begin
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
    end else begin
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && in_valid && !skid_vld_r) begin
      skid_r <= in_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Operand prep: select width, take magnitudes for the signed kind
  // ---------------------------------------------------------------------------
  logic [HalfW-1:0] n32, d32, na32, da32;
  logic             is64, sgn, nneg, dneg;
  div_stage_t       prep_nxt;

  always_comb begin
    n32  = src.numerator[HalfW-1:0];
    d32  = src.denominator[HalfW-1:0];
    is64 = (src.req_type == KIND_U64_DIVMOD);
    sgn  = (src.req_type == KIND_S32_DIV);
    nneg = sgn && n32[HalfW-1];
    dneg = sgn && d32[HalfW-1];
    na32 = nneg ? (HalfW'(0) - n32) : n32;
    da32 = dneg ? (HalfW'(0) - d32) : d32;

    prep_nxt.kind = src.req_type;
    prep_nxt.nq   = is64 ? src.numerator   : {{HalfW{1'b0}}, na32};
    prep_nxt.dvs  = is64 ? src.denominator : {{HalfW{1'b0}}, da32};
    prep_nxt.rem  = '0;
    prep_nxt.qneg = nneg ^ dneg;
    prep_nxt.rneg = nneg;
    prep_nxt.dz   = is64 ? (src.denominator == '0) : (d32 == '0);
    prep_nxt.nz   = is64 ? (src.numerator == '0)   : (n32 == '0);
  end

  // ---------------------------------------------------------------------------
  // Divide stages: one trial subtract each
  // ---------------------------------------------------------------------------
  logic       vld_r [Steps+1];
  div_stage_t st_r  [Steps+1];
  div_stage_t st_nxt[Steps];

  function automatic div_stage_t div_step(input div_stage_t s);
    logic [DataW:0]   shifted;
    logic [DataW+1:0] diff;
    div_stage_t       o;
    shifted = {s.rem, s.nq[DataW-1]};
    diff    = {1'b0, shifted} - {2'b00, s.dvs};
    o       = s;
    // diff[DataW+1] is the borrow: keep the shifted remainder on a miss
    o.rem   = diff[DataW+1] ? shifted[DataW-1:0] : diff[DataW-1:0];
    o.nq    = {s.nq[DataW-2:0], ~diff[DataW+1]};
    return o;
  endfunction

  always_comb begin
    for (int i = 0; i < Steps; i++) begin
      st_nxt[i] = div_step(st_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= Steps; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= src_vld;
      for (int i = 0; i < Steps; i++) begin
        vld_r[i+1] <= vld_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= prep_nxt;
      for (int i = 0; i < Steps; i++) begin
        st_r[i+1] <= st_nxt[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Fix-up: divide by zero, signs, output register
  // ---------------------------------------------------------------------------
  div_stage_t       fin;
  logic [HalfW-1:0] q32, r32;

  always_comb begin
    fin = st_r[Steps];
    q32 = fin.qneg ? (HalfW'(0) - fin.nq[HalfW-1:0])  : fin.nq[HalfW-1:0];
    r32 = fin.rneg ? (HalfW'(0) - fin.rem[HalfW-1:0]) : fin.rem[HalfW-1:0];
    out_data_nxt.div_by_zero = fin.dz;
    if (fin.dz) begin
      out_data_nxt.remainder = '0;
      if (fin.nz) begin
        out_data_nxt.quotient = '0;
      end else if (fin.kind == KIND_U64_DIVMOD) begin
        out_data_nxt.quotient = SIGN_BIT_64;
      end else begin
        out_data_nxt.quotient = SIGN_BIT_32;
      end
    end else if (fin.kind == KIND_S32_DIV) begin
      out_data_nxt.quotient  = {{HalfW{1'b0}}, q32};
      out_data_nxt.remainder = {{HalfW{1'b0}}, r32};
    end else begin
      out_data_nxt.quotient  = fin.nq;
      out_data_nxt.remainder = fin.rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[Steps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `IDU_ASSERT_NXT(a_skid_catches, in_valid && !in_stall && !adv, skid_vld_r)
  `IDU_ASSERT_NXT(a_last_to_out, adv && vld_r[Steps], out_valid_r)
  `IDU_ASSERT_IMP(a_dz_rem_zero, out_valid_r && out_data_r.div_by_zero,
                  out_data_r.remainder == '0)
  `IDU_ASSERT_IMP(a_narrow_upper,
                  vld_r[Steps] && !fin.dz && (fin.kind != KIND_U64_DIVMOD),
                  fin.nq[DataW-1:HalfW] == '0 && fin.rem[DataW-1:HalfW] == '0)

endmodule : integer_divmod_unit

`default_nettype wire
